### sv/kmp_pkg.sv
`timescale 1ns / 1ps
// kmp_pkg: shared types, constants and helpers of the KMP substring matcher.
// No dependencies.
package kmp_pkg;

	localparam int PATTERN_MAX  = 32;
	localparam int IDX_W        = $clog2(PATTERN_MAX);
	localparam int LEN_W        = IDX_W + 1;
	localparam int PATTERN_BITS = PATTERN_MAX * 8;
	localparam int CFG_DATA_W   = 64;
	localparam int CFG_IDX_W    = 3;
	localparam int QUEUE_DEPTH  = 4;
	localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);

	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_3 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd4;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       string_end;
	} kmp_in_t;

	typedef struct packed {
		logic match_here;
		logic found;
		logic last;
	} kmp_out_t;

	typedef struct packed {
		logic             busy;
		logic             clr;
		logic [LEN_W-1:0] len;
		logic [IDX_W-1:0] last_fail;
	} kmp_tbl_status_t;

	typedef struct packed {
		logic [IDX_W-1:0] fail;
		logic [7:0]       pbyte;
	} kmp_tbl_rd_t;

	typedef enum logic {
		TB_IDLE,
		TB_BUILD
	} kmp_tb_state_t;

	function automatic logic [7:0] pat_byte(input logic [PATTERN_BITS-1:0] p,
			input logic [IDX_W-1:0] idx);
		return p[idx*8 +: 8];
	endfunction

endpackage

### sv/kmp_front.sv
`timescale 1ns / 1ps
// kmp_front: input transfer side, a short queue of text bytes for the engine.
// Depends on kmp_pkg.
module kmp_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  kmp_pkg::kmp_in_t  in_data,
	output logic              q_valid,
	input  logic              q_pop,
	output kmp_pkg::kmp_in_t  q_data
);
	import kmp_pkg::*;

	kmp_in_t              mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]  wr_ptr_q;
	logic [QUEUE_AW-1:0]  rd_ptr_q;
	logic [QUEUE_AW:0]    count_q;
	logic                 push;
	logic                 pop;

	assign in_stall = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign push     = in_valid && !in_stall;
	assign q_valid  = (count_q != '0);
	assign pop      = q_pop && q_valid;
	assign q_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### sv/kmp_table.sv
`timescale 1ns / 1ps
// kmp_table: pattern registers and failure table builder, one step per cycle.
// Depends on kmp_pkg.
module kmp_table (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [kmp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [kmp_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic [kmp_pkg::IDX_W-1:0]       rd_idx,
	output kmp_pkg::kmp_tbl_rd_t            rd,
	output kmp_pkg::kmp_tbl_status_t        status
);
	import kmp_pkg::*;

	kmp_tb_state_t           state_q;
	kmp_tb_state_t           state_d;
	logic [PATTERN_BITS-1:0] pat_q;
	logic [LEN_W-1:0]        len_q;
	logic [LEN_W-1:0]        len_new;
	logic [IDX_W-1:0]        fail_q [PATTERN_MAX];
	logic [IDX_W-1:0]        last_fail_q;
	logic [IDX_W-1:0]        i_q;
	logic [IDX_W-1:0]        k_q;
	logic [IDX_W-1:0]        fail_addr;
	logic [IDX_W-1:0]        fail_rd;
	logic [IDX_W-1:0]        k_next;
	logic                    start;
	logic                    eq;
	logic                    back_off;
	logic                    at_end;
	logic                    last_step;

	assign start = cfg_write && (cfg_index <= REG_PATTERN_LENGTH);

	always_comb begin
		if (cfg_data[LEN_W-1:0] == '0) begin
			len_new = LEN_W'(1);
		end else if (cfg_data[LEN_W-1:0] > LEN_W'(PATTERN_MAX)) begin
			len_new = LEN_W'(PATTERN_MAX);
		end else begin
			len_new = cfg_data[LEN_W-1:0];
		end
	end

	// rd.pbyte is the pattern byte at rd_idx, rd.fail the entry below it while idle
	assign fail_addr = (state_q == TB_BUILD) ? IDX_W'(k_q - 1'b1) : IDX_W'(rd_idx - 1'b1);
	assign fail_rd   = fail_q[fail_addr];
	assign rd.fail   = fail_rd;
	assign rd.pbyte  = pat_byte(pat_q, rd_idx);

	assign eq        = (pat_byte(pat_q, k_q) == pat_byte(pat_q, i_q));
	assign back_off  = (k_q != '0) && !eq;
	assign k_next    = k_q + IDX_W'(eq);
	assign at_end    = ({1'b0, i_q} >= len_q);
	assign last_step = ({1'b0, i_q} == LEN_W'(len_q - 1'b1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			TB_IDLE: begin
				if (start) begin
					state_d = TB_BUILD;
				end
			end
			TB_BUILD: begin
				if (start) begin
					state_d = TB_BUILD;
				end else if (at_end || (!back_off && last_step)) begin
					state_d = TB_IDLE;
				end
			end
			default: state_d = TB_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= TB_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q       <= '0;
			len_q       <= LEN_W'(1);
			last_fail_q <= '0;
			i_q         <= IDX_W'(1);
			k_q         <= '0;
		end else if (start) begin
			case (cfg_index)
				REG_PATTERN_WORD_0: pat_q[0*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
				REG_PATTERN_WORD_1: pat_q[1*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
				REG_PATTERN_WORD_2: pat_q[2*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
				REG_PATTERN_WORD_3: pat_q[3*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
				REG_PATTERN_LENGTH: len_q <= len_new;
				default:            len_q <= len_q;
			endcase
			i_q <= IDX_W'(1);
			k_q <= '0;
		end else if (state_q == TB_BUILD) begin
			if (at_end) begin
				last_fail_q <= '0;
			end else if (back_off) begin
				k_q <= fail_rd;
			end else begin
				k_q <= k_next;
				i_q <= i_q + 1'b1;
				if (last_step) begin
					last_fail_q <= k_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			fail_q[0] <= '0;
		end else if (state_q == TB_BUILD && !at_end && !back_off) begin
			fail_q[i_q] <= k_next;
		end
	end

	assign status.busy      = (state_q == TB_BUILD);
	assign status.clr       = start;
	assign status.len       = len_q;
	assign status.last_fail = last_fail_q;

endmodule

### sv/kmp_back.sv
`timescale 1ns / 1ps
// kmp_back: match engine and output register; one compare or fallback per cycle
// while a byte is held and the output is not stalled. Depends on kmp_pkg.
module kmp_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_valid,
	output logic                       q_pop,
	input  kmp_pkg::kmp_in_t           q_data,
	input  kmp_pkg::kmp_tbl_status_t   status,
	output logic [kmp_pkg::IDX_W-1:0]  rd_idx,
	input  kmp_pkg::kmp_tbl_rd_t       rd,
	output logic                       out_valid,
	input  logic                       out_stall,
	output kmp_pkg::kmp_out_t          out_data
);
	import kmp_pkg::*;

	kmp_in_t           cur_q;
	logic              busy_q;
	logic [LEN_W-1:0]  v_q;
	logic              found_q;
	logic              out_valid_q;
	kmp_out_t          out_q;
	logic [LEN_W-1:0]  v_eff;
	logic [LEN_W-1:0]  v_inc;
	logic [LEN_W-1:0]  v_new;
	logic              eq;
	logic              fallback;
	logic              hit;
	logic              out_free;
	logic              finish;

	assign v_eff    = (v_q >= status.len) ? '0 : v_q;
	assign rd_idx   = IDX_W'(v_eff);
	assign eq       = (rd.pbyte == cur_q.text_byte);
	assign fallback = (v_eff != '0) && !eq;
	assign v_inc    = v_eff + LEN_W'(eq);
	assign hit      = (v_inc >= status.len);
	assign v_new    = hit ? {1'b0, status.last_fail} : v_inc;

	assign out_free = !out_valid_q || !out_stall;
	assign finish   = busy_q && !fallback && out_free;
	assign q_pop    = q_valid && !status.busy && (!busy_q || finish);

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_data;
		end
		if (finish) begin
			out_q.match_here <= hit;
			out_q.found      <= found_q || hit;
			out_q.last       <= cur_q.string_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			v_q         <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
			end else if (finish) begin
				busy_q <= 1'b0;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (status.clr) begin
				v_q     <= '0;
				found_q <= 1'b0;
			end else if (busy_q && fallback) begin
				v_q <= {1'b0, rd.fail};
			end else if (finish) begin
				v_q     <= cur_q.string_end ? '0 : v_new;
				found_q <= cur_q.string_end ? 1'b0 : (found_q || hit);
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

### sv/kmp_substring_matcher_unit.sv
`timescale 1ns / 1ps
// kmp_substring_matcher_unit: top level of the streamed KMP substring matcher.
// Depends on kmp_pkg, kmp_front, kmp_table and kmp_back.
//
// Searches byte streams for a pattern of 1 to 32 bytes and returns one result per
// byte: match_here when the pattern ends on that byte (overlapping hits included),
// found once it has occurred in the current string, and last echoing string_end,
// after which the match state clears. A byte takes a compare in the match engine
// plus a failure-table fallback for each retry after a mismatch; fallbacks never
// outnumber the bytes that advanced the match. A four-entry input queue and an
// output register let both sides stall freely. Every write to a valid register
// index resets the match state and rebuilds the failure table; bytes sent
// meanwhile wait in the queue until the build is done.
module kmp_substring_matcher_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [kmp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [kmp_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  kmp_pkg::kmp_in_t                in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output kmp_pkg::kmp_out_t               out_data
);
	import kmp_pkg::*;

	logic             q_valid;
	logic             q_pop;
	kmp_in_t          q_data;
	logic [IDX_W-1:0] rd_idx;
	kmp_tbl_rd_t      rd;
	kmp_tbl_status_t  status;

	kmp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_data   (q_data)
	);

	kmp_table u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rd_idx    (rd_idx),
		.rd        (rd),
		.status    (status)
	);

	kmp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_data    (q_data),
		.status    (status),
		.rd_idx    (rd_idx),
		.rd        (rd),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

### sim/tb_kmp_substring_matcher_unit.sv
`timescale 1ns / 1ps
// tb_kmp_substring_matcher_unit: self-checking testbench of the streamed KMP matcher.
// Depends on kmp_pkg and kmp_substring_matcher_unit; predicts every result with its
// own failure-table search and checks transfers in order under random stalls.
module tb_kmp_substring_matcher_unit;
	import kmp_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int HOLD_CYCLES   = 300;
	localparam int RANDOM_PHASES = 20;
	localparam int PHASE_BYTES   = 85;
	localparam logic [CFG_IDX_W-1:0] REG_NONE_FIRST = REG_PATTERN_LENGTH + 3'd1;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	kmp_in_t               in_data = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	kmp_out_t              out_data;

	kmp_substring_matcher_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// search state mirrored from the block
	logic [63:0] pat_words [4];
	logic [5:0]  len_reg;
	int unsigned pat_len;
	logic [5:0]  fail_tbl [PATTERN_MAX];
	int unsigned run_len;
	logic        seen;

	kmp_in_t  pending_bytes [$];
	kmp_out_t awaited_results [$];
	int       bytes_queued = 0;
	int       bytes_accepted = 0;
	int       errors = 0;
	int       cycle_count = 0;
	int       gap_left = 0;
	int       stall_left = 0;
	int       long_holds_asked = 0;
	int       long_holds_done = 0;
	bit       sender_idles = 1'b1;
	bit       receiver_idles = 1'b1;

	// stimulus pattern and text alphabet
	logic [7:0] stim_pat [PATTERN_MAX];
	int         stim_len;
	logic [7:0] alpha [3];
	int         alpha_n;
	bit         wide_alpha;

	function automatic logic [7:0] pattern_at(int unsigned i);
		return pat_words[(i >> 3) & 3][(i & 7) * 8 +: 8];
	endfunction

	function automatic void build_failure_table();
		int unsigned k;
		int unsigned len;
		len = len_reg;
		if (len == 0) len = 1;
		if (len > PATTERN_MAX) len = PATTERN_MAX;
		pat_len = len;
		k = 0;
		foreach (fail_tbl[i]) fail_tbl[i] = '0;
		for (int unsigned i = 1; i < len; i++) begin
			while (k > 0 && pattern_at(k) != pattern_at(i)) k = fail_tbl[k - 1];
			if (pattern_at(k) == pattern_at(i)) k++;
			fail_tbl[i] = 6'(k);
		end
		run_len = 0;
		seen = 1'b0;
	endfunction

	function automatic kmp_out_t predict_search(kmp_in_t item);
		kmp_out_t res;
		int unsigned v;
		v = run_len;
		if (v >= pat_len) v = 0;
		while (v > 0 && pattern_at(v) != item.text_byte) v = fail_tbl[v - 1];
		if (pattern_at(v) == item.text_byte) v++;
		res.match_here = 1'b0;
		if (v >= pat_len) begin
			res.match_here = 1'b1;
			seen = 1'b1;
			v = fail_tbl[pat_len - 1];
		end
		run_len = v;
		res.found = seen;
		res.last = item.string_end;
		if (item.string_end) begin
			run_len = 0;
			seen = 1'b0;
		end
		return res;
	endfunction

	function automatic logic [7:0] pick_sym();
		if (wide_alpha) return 8'($urandom);
		return alpha[$urandom_range(0, alpha_n - 1)];
	endfunction

	function automatic logic [63:0] stim_word(int r);
		logic [63:0] w;
		for (int b = 0; b < 8; b++) w[b * 8 +: 8] = stim_pat[r * 8 + b];
		return w;
	endfunction

	// only called while idle, so the mirror can change at once
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		if (idx <= REG_PATTERN_WORD_3) begin
			pat_words[idx[1:0]] = data;
			build_failure_table();
		end else if (idx == REG_PATTERN_LENGTH) begin
			len_reg = data[5:0];
			build_failure_table();
		end
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic load_pattern(input int len_code);
		logic [63:0] w;
		write_reg(REG_PATTERN_WORD_0, stim_word(0));
		write_reg(REG_PATTERN_WORD_1, stim_word(1));
		write_reg(REG_PATTERN_WORD_2, stim_word(2));
		write_reg(REG_PATTERN_WORD_3, stim_word(3));
		w = {$urandom, $urandom};
		w[5:0] = 6'(len_code);
		write_reg(REG_PATTERN_LENGTH, w);
	endtask

	task automatic queue_byte(input logic [7:0] b, input logic str_end);
		kmp_in_t item;
		item.text_byte = b;
		item.string_end = str_end;
		pending_bytes.push_back(item);
		bytes_queued++;
	endtask

	// strings of alphabet symbols with pattern copies and some noise
	task automatic queue_text(input int n);
		logic [7:0] s [$];
		int left;
		int slen;
		int r;
		int cut;
		bit close_last;
		left = n;
		close_last = $urandom_range(0, 3) != 0;
		while (left > 0) begin
			slen = $urandom_range(1, 8 + 2 * stim_len);
			if (slen > left) slen = left;
			s.delete();
			while (s.size() < slen) begin
				r = $urandom_range(0, 9);
				if (r < 3) begin
					cut = (r == 0) ? $urandom_range(1, stim_len) : stim_len;
					for (int i = 0; i < cut; i++) s.push_back(stim_pat[i]);
				end else if (r == 9) begin
					s.push_back(8'($urandom));
				end else begin
					s.push_back(pick_sym());
				end
			end
			while (s.size() > slen) void'(s.pop_back());
			left -= slen;
			for (int i = 0; i < slen; i++)
				queue_byte(s[i], i == slen - 1 && (left > 0 || close_last));
		end
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (bytes_accepted != bytes_queued || awaited_results.size() != 0);
	endtask

	always @(posedge clk) begin : drive_bytes
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid) begin
				awaited_results.push_back(predict_search(in_data));
				bytes_accepted++;
			end
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (sender_idles && $urandom_range(0, 5) == 0) begin
				gap_left <= $urandom_range(0, 14);
				in_valid <= 1'b0;
			end else if (pending_bytes.size() != 0) begin
				in_valid <= 1'b1;
				in_data <= pending_bytes.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : stall_results
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (long_holds_done < long_holds_asked) begin
			long_holds_done <= long_holds_done + 1;
			stall_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (receiver_idles && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 14);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin : check_results
		kmp_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_results.size() == 0) begin
				$display("%0t: unexpected transfer, got match_here=%b found=%b last=%b",
					$time, out_data.match_here, out_data.found, out_data.last);
				errors++;
			end else begin
				want = awaited_results.pop_front();
				if (out_data !== want) begin
					$display("%0t: expected match_here=%b found=%b last=%b, got %b %b %b",
						$time, want.match_here, want.found, want.last,
						out_data.match_here, out_data.found, out_data.last);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_kmp_substring_matcher_unit: errors");
			$finish;
		end
	end

	initial begin : stimulus
		int extreme_lens [5];
		int len_code;
		bit calm;
		extreme_lens = '{32, 33, 63, 0, 1};
		foreach (pat_words[i]) pat_words[i] = '0;
		len_reg = 6'd1;
		build_failure_table();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// reset pattern: a single zero byte
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h00, 1'b1);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'h80, 1'b1);
		wait_drained();

		// length zero reads as one
		write_reg(REG_PATTERN_WORD_0, 64'hFF);
		write_reg(REG_PATTERN_LENGTH, 64'd0);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'hFF, 1'b1);
		wait_drained();

		// overlapping hits
		write_reg(REG_PATTERN_WORD_0, 64'h6161);
		write_reg(REG_PATTERN_LENGTH, 64'd2);
		queue_byte(8'h61, 1'b0);
		queue_byte(8'h61, 1'b0);
		queue_byte(8'h61, 1'b0);
		queue_byte(8'h62, 1'b1);
		wait_drained();

		// fallback and retry, with an ignored write inside the string
		write_reg(REG_PATTERN_WORD_0, 64'h62616261);
		write_reg(REG_PATTERN_LENGTH, 64'd4);
		queue_byte(8'h61, 1'b0);
		queue_byte(8'h62, 1'b0);
		queue_byte(8'h61, 1'b0);
		queue_byte(8'h61, 1'b0);
		queue_byte(8'h62, 1'b0);
		wait_drained();
		write_reg(REG_NONE_FIRST, {$urandom, $urandom});
		queue_byte(8'h61, 1'b0);
		queue_byte(8'h62, 1'b0);
		queue_byte(8'h61, 1'b0);
		queue_byte(8'h62, 1'b1);
		wait_drained();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			calm = p >= RANDOM_PHASES - 2;
			sender_idles = !calm && $urandom_range(0, 3) != 0;
			receiver_idles = !calm && $urandom_range(0, 3) != 0;
			if (p < 5) len_code = extreme_lens[p];
			else if ($urandom_range(0, 3) != 0) len_code = $urandom_range(1, 8);
			else len_code = $urandom_range(9, PATTERN_MAX);
			stim_len = (len_code == 0) ? 1 : (len_code > PATTERN_MAX ? PATTERN_MAX : len_code);
			alpha_n = $urandom_range(1, 3);
			wide_alpha = $urandom_range(0, 4) == 0;
			foreach (alpha[i]) alpha[i] = 8'($urandom);
			foreach (stim_pat[i]) stim_pat[i] = (i < stim_len) ? pick_sym() : 8'($urandom);
			load_pattern(len_code);
			if ($urandom_range(0, 3) == 0)
				write_reg(CFG_IDX_W'(REG_NONE_FIRST + $urandom_range(0, 2)),
					{$urandom, $urandom});
			if (p == 3) long_holds_asked++;
			queue_text(PHASE_BYTES);
			wait_drained();
		end

		repeat (20) @(posedge clk);
		if (errors == 0 && awaited_results.size() == 0) begin
			$display("tb_kmp_substring_matcher_unit: clean");
		end else begin
			$display("tb_kmp_substring_matcher_unit: errors");
		end
		$finish;
	end

endmodule

### kmp_substring_matcher_unit.f
sv/kmp_pkg.sv
sv/kmp_front.sv
sv/kmp_table.sv
sv/kmp_back.sv
sv/kmp_substring_matcher_unit.sv
sim/tb_kmp_substring_matcher_unit.sv
